// ===== hdl/dhtp_pkg.sv =====
// shared types and constants for the decimal / hex token parser
package dhtp_pkg;

  // parse status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // digit count saturation point
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // character codes
  localparam logic [7:0] CH_0  = 8'h30;  // '0'
  localparam logic [7:0] CH_9  = 8'h39;  // '9'
  localparam logic [7:0] CH_LA = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF = 8'h46;  // 'F'

  // value of the first letter digit
  localparam logic [7:0] HEX_TEN = 8'd10;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input request
  typedef struct packed {
    logic [7:0] char_code;
    logic       token_start;
  } in_req_t;

  // result request
  typedef struct packed {
    logic [63:0] parsed_value;
    logic [1:0]  parse_status;
    logic [15:0] digits_consumed;
  } out_req_t;

  // classified character as it waits in the queue
  typedef struct packed {
    logic       start;
    logic       is_digit;
    logic [3:0] digit;
  } qent_t;

endpackage

// ===== hdl/dhtp_front.sv =====
// front end: character classification and the queue toward the back end
module dhtp_front #(
  parameter int DEPTH = dhtp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              hex_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  dhtp_pkg::in_req_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output dhtp_pkg::qent_t   q_head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dhtp_pkg::qent_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  dhtp_pkg::qent_t  cls;
  logic [7:0]       diff;
  logic             push, pop;

  // classify the incoming character in the current base
  always_comb begin
    cls.start    = in_data.token_start;
    cls.is_digit = 1'b0;
    diff         = 8'd0;
    if (in_data.char_code inside {[dhtp_pkg::CH_0:dhtp_pkg::CH_9]}) begin
      cls.is_digit = 1'b1;
      diff         = in_data.char_code - dhtp_pkg::CH_0;
    end else if (hex_mode &&
                 (in_data.char_code inside {[dhtp_pkg::CH_LA:dhtp_pkg::CH_LF]})) begin
      cls.is_digit = 1'b1;
      diff         = in_data.char_code - dhtp_pkg::CH_LA + dhtp_pkg::HEX_TEN;
    end else if (hex_mode &&
                 (in_data.char_code inside {[dhtp_pkg::CH_UA:dhtp_pkg::CH_UF]})) begin
      cls.is_digit = 1'b1;
      diff         = in_data.char_code - dhtp_pkg::CH_UA + dhtp_pkg::HEX_TEN;
    end
    cls.digit = diff[3:0];
  end

  // queue handshakes
  assign in_ready = (cnt_r != CNT_FULL);
  assign q_valid  = (cnt_r != '0);
  assign q_head   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

  // fill count stays within the queue depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue fill count beyond depth");

  // a push without a pop grows the queue by one
  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("queue count did not follow push");

  // pointers stay together when the queue is empty
  a_ptr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers apart while empty");

endmodule

// ===== hdl/dhtp_back.sv =====
// back end: digit accumulation, token termination and the result register
module dhtp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hex_mode,
  input  logic               q_valid,
  output logic               q_ready,
  input  dhtp_pkg::qent_t    q_head,
  output logic               out_valid,
  input  logic               out_ready,
  output dhtp_pkg::out_req_t out_data
);

  logic [63:0]        acc_r, acc_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic               active_r, active_nxt;
  logic               out_valid_r, out_valid_nxt;
  dhtp_pkg::out_req_t out_data_r, out_data_nxt;
  logic               pop;
  logic               active;
  logic [63:0]        acc_base;
  logic [15:0]        cnt_base;
  logic [67:0]        scaled;
  logic [67:0]        sum;
  logic               ovf;

  // the head is taken whenever the result register is free or draining
  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  // scale by the base and add the digit, with four guard bits
  always_comb begin
    acc_base = q_head.start ? 64'd0 : acc_r;
    cnt_base = q_head.start ? 16'd0 : cnt_r;
    active   = q_head.start || active_r;
    if (hex_mode) begin
      scaled = {acc_base, 4'b0000};
    end else begin
      scaled = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0};
    end
    sum = scaled + {64'd0, q_head.digit};
    ovf = |sum[67:64];
  end

  // token state and result selection
  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (pop) begin
      acc_nxt    = acc_base;
      cnt_nxt    = cnt_base;
      active_nxt = active;
      if (active) begin
        if (!q_head.is_digit) begin
          // terminator ends the token
          active_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          if (cnt_base == 16'd0) begin
            out_data_nxt.parsed_value    = 64'd0;
            out_data_nxt.parse_status    = dhtp_pkg::ST_NO_DIGITS;
            out_data_nxt.digits_consumed = 16'd0;
          end else begin
            out_data_nxt.parsed_value    = acc_base;
            out_data_nxt.parse_status    = dhtp_pkg::ST_OK;
            out_data_nxt.digits_consumed = cnt_base;
          end
        end else if (ovf) begin
          // digit would carry past 64 bits
          active_nxt                   = 1'b0;
          out_valid_nxt                = 1'b1;
          out_data_nxt.parsed_value    = 64'd0;
          out_data_nxt.parse_status    = dhtp_pkg::ST_OVERFLOW;
          out_data_nxt.digits_consumed = cnt_base;
        end else begin
          acc_nxt = sum[63:0];
          cnt_nxt = (cnt_base == dhtp_pkg::COUNT_MAX) ? cnt_base : cnt_base + 16'd1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= 64'd0;
      cnt_r       <= 16'd0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an ok result always carries at least one digit
  a_ok_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.parse_status == dhtp_pkg::ST_OK))
      |-> (out_data_r.digits_consumed != 16'd0))
    else $error("ok result without digits");

  // an empty token reports zero value and zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.parse_status == dhtp_pkg::ST_NO_DIGITS))
      |-> ((out_data_r.parsed_value == 64'd0) && (out_data_r.digits_consumed == 16'd0)))
    else $error("empty token result not zero");

  // an overflow result carries a zero value
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.parse_status == dhtp_pkg::ST_OVERFLOW))
      |-> (out_data_r.parsed_value == 64'd0))
    else $error("overflow result with nonzero value");

  // every result ends the token
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> !active_r)
    else $error("token still active after result");

endmodule

// ===== hdl/decimal_hex_token_parser.sv =====
// top level of the decimal / hex token parser
//
//  channel  | ports                              | moves
//  ---------+------------------------------------+---------------------------------
//  input    | in_valid, in_ready, in_data        | one character and start flag
//  result   | out_valid, out_ready, out_data     | value, status, digit count
//  config   | cfg_wr_en, cfg_wr_data             | hex_mode, no wait, no read-back
//
// one character per cycle sustained while results drain; the back end scales
// and adds one digit per cycle with a 68-bit add and carry check
// a token's ending request is queued first; its result is then registered
// reset (rst_n low, synchronous) empties the queue, drops any token and
// clears hex_mode to decimal
// a stalled result holds the back end; the queue keeps taking requests until full
module decimal_hex_token_parser #(
  parameter int QUEUE_DEPTH = dhtp_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dhtp_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dhtp_pkg::out_req_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  logic            hex_mode_r, hex_mode_nxt;
  logic            q_valid, q_ready;
  dhtp_pkg::qent_t q_head;

  // mode register
  assign hex_mode_nxt = cfg_wr_en ? cfg_wr_data : hex_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_mode_r <= 1'b0;
    end else begin
      hex_mode_r <= hex_mode_nxt;
    end
  end

  // classification and queue
  dhtp_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .hex_mode (hex_mode_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_head   (q_head)
  );

  // accumulation and results
  dhtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hex_mode  (hex_mode_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_head    (q_head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
